// ===== rtl/ipv4_source_match_address_rewrite_macros.svh =====
// Assertion macros shared by the address rewrite block.
`ifndef IPV4_SOURCE_MATCH_ADDRESS_REWRITE_MACROS_SVH
`define IPV4_SOURCE_MATCH_ADDRESS_REWRITE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISMAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ismar assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ISMAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ismar assertion failed");

`endif

// ===== rtl/ismar_pkg.sv =====
// Types and constants of the IPv4 source match address rewrite block.
package ismar_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int IDX_W             = 8;
  localparam int CFG_AW            = 3;

  localparam logic [31:0] OFFSET_RESET     = 32'h0000_0100;
  localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;

  localparam logic       REG_ADDRESS_OFFSET = 1'b0;

  localparam logic [1:0] KIND_SUBSCRIBE   = 2'd0;
  localparam logic [1:0] KIND_UNSUBSCRIBE = 2'd1;
  localparam int         KIND_PACKET_BIT  = 1;

  localparam logic [2:0] ST_DELIVERED   = 3'd0;
  localparam logic [2:0] ST_NO_SINK     = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
  localparam logic [2:0] ST_SUBSCRIBED  = 3'd3;
  localparam logic [2:0] ST_PRESENT     = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd5;
  localparam logic [2:0] ST_UNSUB_DONE  = 3'd6;

  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [7:0]       sink;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } carry_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [31:0]      addr;
    logic [7:0]       sink;
  } wcmd_t;

endpackage

// ===== rtl/ipv4_source_match_address_rewrite.sv =====
// Top level: item control, APB offset register, entry chain and result register.
//
// Input channel (in_valid/in_ready) takes one item: subscribe, unsubscribe or
// packet header. Every item yields exactly one result on the output channel
// (out_valid/out_ready) carrying a status and, for a delivered packet, the
// sink, the rewritten addresses and a new header checksum.
// A lookup walks a carry through a chain of TABLE_ENTRIES cells, one cell per
// cycle, each cell holding the carry in its own register; the chain end is
// caught in a final register, and the result waits in S_FIN until the output
// register is free. A new item is taken only after the last result leaves S_FIN.
// The APB port holds address_offset at byte address 0; pready is always high.
// Write it only while no item is in flight.
// Reset empties the table, sets the offset to 0x100 and clears both channels.
// When the receiver stalls, the result holds in the output register; one more
// item may be taken and scanned, and its result waits until the register frees.
module ipv4_source_match_address_rewrite #(
  parameter int TABLE_ENTRIES = ismar_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_kind,
  input  logic [31:0]                  in_source_address,
  input  logic [31:0]                  in_destination_address,
  input  logic [31:0]                  in_header_first_word,
  input  logic [31:0]                  in_header_second_word,
  input  logic [15:0]                  in_ttl_and_protocol,
  input  logic [7:0]                   in_sink_number,
  input  logic [15:0]                  in_packet_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_status,
  output logic [7:0]                   out_sink_out,
  output logic [31:0]                  out_new_source,
  output logic [31:0]                  out_new_destination,
  output logic [15:0]                  out_header_checksum,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ismar_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ismar_pkg::*;

  `include "ipv4_source_match_address_rewrite_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   start_r;
  logic   accept;
  logic   fire;

  logic [31:0] offset_r;

  logic [1:0]  kind_r;
  logic [31:0] src_r;
  logic [31:0] nsrc_r;
  logic [31:0] ndst_r;
  logic [31:0] w0_r;
  logic [31:0] w1_r;
  logic [15:0] tp_r;
  logic [7:0]  sink_r;
  logic        len_ok_r;

  carry_t                   carry [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] match_vec;
  carry_t                   fin_r;
  wcmd_t                    wcmd;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, status_nxt;
  logic [7:0]  out_sink_r, osink_nxt;
  logic [31:0] out_src_r, osrc_nxt;
  logic [31:0] out_dst_r, odst_nxt;
  logic [15:0] out_csum_r, ocsum_nxt;

  logic [19:0] sum20;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ADDRESS_OFFSET) ? offset_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ADDRESS_OFFSET)) begin
      offset_r <= pwdata;
    end
  end

  // item control
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (carry[TABLE_ENTRIES].active) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_kind;
      src_r    <= in_source_address;
      nsrc_r   <= in_source_address - offset_r;
      ndst_r   <= in_destination_address + offset_r;
      w0_r     <= in_header_first_word;
      w1_r     <= in_header_second_word;
      tp_r     <= in_ttl_and_protocol;
      sink_r   <= in_sink_number;
      len_ok_r <= (in_packet_length >= MIN_HEADER_BYTES);
    end
    if ((state_r == S_SCAN) && carry[TABLE_ENTRIES].active) begin
      fin_r <= carry[TABLE_ENTRIES];
    end
  end

  // entry chain
  always_comb begin
    carry[0]        = '0;
    carry[0].active = start_r;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ismar_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .carry_in (carry[i]),
      .src_addr (src_r),
      .wcmd     (wcmd),
      .carry_out(carry[i+1]),
      .match    (match_vec[i])
    );
  end

  // checksum over rewritten header, checksum word zero
  always_comb begin
    sum20 = 20'(w0_r[31:16]) + 20'(w0_r[15:0]) + 20'(w1_r[31:16]) + 20'(w1_r[15:0])
          + 20'(tp_r) + 20'(nsrc_r[31:16]) + 20'(nsrc_r[15:0])
          + 20'(ndst_r[31:16]) + 20'(ndst_r[15:0]);
    fold1 = 17'(sum20[15:0]) + 17'(sum20[19:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  // result and table update
  always_comb begin
    status_nxt = ST_UNSUB_DONE;
    osink_nxt  = 8'd0;
    osrc_nxt   = 32'd0;
    odst_nxt   = 32'd0;
    ocsum_nxt  = 16'd0;
    wcmd       = '0;
    wcmd.addr  = src_r;
    wcmd.sink  = sink_r;
    if (kind_r[KIND_PACKET_BIT]) begin
      if (!len_ok_r) begin
        status_nxt = ST_TOO_SHORT;
      end else if (!fin_r.hit) begin
        status_nxt = ST_NO_SINK;
      end else begin
        status_nxt = ST_DELIVERED;
        osink_nxt  = fin_r.sink;
        osrc_nxt   = nsrc_r;
        odst_nxt   = ndst_r;
        ocsum_nxt  = ~fold2;
      end
    end else if (kind_r == KIND_SUBSCRIBE) begin
      if (fin_r.hit) begin
        status_nxt = ST_PRESENT;
      end else if (fin_r.free) begin
        status_nxt = ST_SUBSCRIBED;
        wcmd.set   = fire;
        wcmd.idx   = fin_r.free_idx;
      end else begin
        status_nxt = ST_TABLE_FULL;
      end
    end else begin
      status_nxt = ST_UNSUB_DONE;
      wcmd.clr   = fire && fin_r.hit;
      wcmd.idx   = fin_r.hit_idx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= status_nxt;
      out_sink_r   <= osink_nxt;
      out_src_r    <= osrc_nxt;
      out_dst_r    <= odst_nxt;
      out_csum_r   <= ocsum_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_sink_out        = out_sink_r;
  assign out_new_source      = out_src_r;
  assign out_new_destination = out_dst_r;
  assign out_header_checksum = out_csum_r;

  `ISMAR_ASSERT_NEXT(a_accept_starts_scan, accept, start_r && (state_r == S_SCAN))
  `ISMAR_ASSERT_NOW(a_single_match, 1'b1, $onehot0(match_vec))
  `ISMAR_ASSERT_NEXT(a_chain_end_finishes,
    (state_r == S_SCAN) && carry[TABLE_ENTRIES].active, state_r == S_FIN)

endmodule

// ===== rtl/ismar_cell.sv =====
// One table entry of the scan chain: compares, records first free slot, passes carry on.
module ismar_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ismar_pkg::carry_t carry_in,
  input  logic [31:0]       src_addr,
  input  ismar_pkg::wcmd_t  wcmd,
  output ismar_pkg::carry_t carry_out,
  output logic              match
);
  import ismar_pkg::*;

  localparam logic [IDX_W-1:0] IDX_C = IDX_W'(IDX);

  logic        valid_r, valid_nxt;
  logic [31:0] addr_r;
  logic [7:0]  sink_r;
  carry_t      carry_r, carry_nxt;
  logic        hit_here;
  logic        sel;

  assign hit_here = valid_r && (addr_r == src_addr);
  assign match    = hit_here && carry_in.active;
  assign sel      = (wcmd.idx == IDX_C);

  always_comb begin
    carry_nxt = carry_in;
    if (hit_here && !carry_in.hit) begin
      carry_nxt.hit     = 1'b1;
      carry_nxt.hit_idx = IDX_C;
      carry_nxt.sink    = sink_r;
    end
    if (!valid_r && !carry_in.free) begin
      carry_nxt.free     = 1'b1;
      carry_nxt.free_idx = IDX_C;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wcmd.set && sel) begin
      valid_nxt = 1'b1;
    end else if (wcmd.clr && sel) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wcmd.set && sel) begin
      addr_r <= wcmd.addr;
      sink_r <= wcmd.sink;
    end
  end

  assign carry_out = carry_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the IPv4 source match address rewrite block.
module tb;
  import ismar_pkg::*;

  localparam logic [1:0] KIND_PACKET     = 2'd2;
  localparam logic [1:0] KIND_PACKET_ALT = 2'd3;
  localparam int POOL_SIZE       = 24;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 2 * (TABLE_ENTRIES_DEF + 3);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [15:0] tp;
    logic [7:0]  sink;
    logic [15:0] len;
  } hdr_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  sink;
    logic [31:0] new_src;
    logic [31:0] new_dst;
    logic [15:0] csum;
  } route_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_source_address = '0;
  logic [31:0] in_destination_address = '0;
  logic [31:0] in_header_first_word = '0;
  logic [31:0] in_header_second_word = '0;
  logic [15:0] in_ttl_and_protocol = '0;
  logic [7:0]  in_sink_number = '0;
  logic [15:0] in_packet_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_sink_out;
  logic [31:0] out_new_source;
  logic [31:0] out_new_destination;
  logic [15:0] out_header_checksum;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  hdr_item_t     items_to_send[$];
  route_result_t route_results_due[$];

  logic        sub_valid[TABLE_ENTRIES_DEF];
  logic [31:0] sub_addr[TABLE_ENTRIES_DEF];
  logic [7:0]  sub_sink[TABLE_ENTRIES_DEF];
  logic [31:0] offset_mirror = OFFSET_RESET;
  logic [31:0] addr_pool[POOL_SIZE];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int status_tally[7];
  int stall_asked = 0;
  int stall_taken = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  ipv4_source_match_address_rewrite u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_kind                (in_kind),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_header_first_word   (in_header_first_word),
    .in_header_second_word  (in_header_second_word),
    .in_ttl_and_protocol    (in_ttl_and_protocol),
    .in_sink_number         (in_sink_number),
    .in_packet_length       (in_packet_length),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_sink_out           (out_sink_out),
    .out_new_source         (out_new_source),
    .out_new_destination    (out_new_destination),
    .out_header_checksum    (out_header_checksum),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] fresh_checksum(logic [31:0] w0, logic [31:0] w1,
                                                 logic [15:0] tp, logic [31:0] s,
                                                 logic [31:0] d);
    logic [19:0] acc;
    acc = 20'(w0[31:16]) + 20'(w0[15:0]) + 20'(w1[31:16]) + 20'(w1[15:0]) + 20'(tp)
        + 20'(s[31:16]) + 20'(s[15:0]) + 20'(d[31:16]) + 20'(d[15:0]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    return ~acc[15:0];
  endfunction

  function automatic route_result_t lookup_and_rewrite(hdr_item_t it);
    route_result_t r;
    int hit;
    int slot;
    r = '{default: '0};
    hit = -1;
    slot = -1;
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (hit < 0 && sub_valid[i] && sub_addr[i] == it.src) hit = i;
      if (slot < 0 && !sub_valid[i]) slot = i;
    end
    if (it.kind[KIND_PACKET_BIT]) begin
      if (it.len < MIN_HEADER_BYTES) begin
        r.status = ST_TOO_SHORT;
      end else if (hit < 0) begin
        r.status = ST_NO_SINK;
      end else begin
        r.status  = ST_DELIVERED;
        r.sink    = sub_sink[hit];
        r.new_src = it.src - offset_mirror;
        r.new_dst = it.dst + offset_mirror;
        r.csum    = fresh_checksum(it.w0, it.w1, it.tp, r.new_src, r.new_dst);
      end
    end else if (it.kind == KIND_SUBSCRIBE) begin
      if (hit >= 0) begin
        r.status = ST_PRESENT;
      end else if (slot < 0) begin
        r.status = ST_TABLE_FULL;
      end else begin
        sub_valid[slot] = 1'b1;
        sub_addr[slot]  = it.src;
        sub_sink[slot]  = it.sink;
        r.status = ST_SUBSCRIBED;
      end
    end else begin
      if (hit >= 0) sub_valid[hit] = 1'b0;
      r.status = ST_UNSUB_DONE;
    end
    return r;
  endfunction

  function automatic hdr_item_t random_item();
    hdr_item_t it;
    int pick;
    it.src  = ($urandom_range(0, 9) < 8) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : $urandom();
    it.dst  = $urandom();
    it.w0   = $urandom();
    it.w1   = $urandom();
    it.tp   = 16'($urandom_range(0, 65535));
    it.sink = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 19);
    if (pick < 2) it.len = 16'($urandom_range(0, 19));
    else if (pick == 2) it.len = ($urandom_range(0, 1) != 0) ? 16'hFFFF : MIN_HEADER_BYTES;
    else it.len = 16'($urandom_range(20, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 25) it.kind = KIND_SUBSCRIBE;
    else if (pick < 40) it.kind = KIND_UNSUBSCRIBE;
    else if (pick < 48) it.kind = KIND_PACKET_ALT;
    else it.kind = KIND_PACKET;
    return it;
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [31:0] src,
                            input logic [31:0] dst, input logic [31:0] w0,
                            input logic [31:0] w1, input logic [15:0] tp,
                            input logic [7:0] sink, input logic [15:0] len);
    items_to_send.push_back('{kind, src, dst, w0, w1, tp, sink, len});
  endtask

  task automatic program_offset(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_ADDRESS_OFFSET);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    offset_mirror = value;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", results_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_items
    hdr_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        route_results_due.push_back(lookup_and_rewrite('{in_kind, in_source_address,
            in_destination_address, in_header_first_word, in_header_second_word,
            in_ttl_and_protocol, in_sink_number, in_packet_length}));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = items_to_send.pop_front();
          in_valid               <= 1'b1;
          in_kind                <= nxt.kind;
          in_source_address      <= nxt.src;
          in_destination_address <= nxt.dst;
          in_header_first_word   <= nxt.w0;
          in_header_second_word  <= nxt.w1;
          in_ttl_and_protocol    <= nxt.tp;
          in_sink_number         <= nxt.sink;
          in_packet_length       <= nxt.len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : accept_results
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_asked != stall_taken) begin
      stall_taken <= stall_asked;
      stall_left  <= HOLD_OFF_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    route_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (route_results_due.size() == 0) begin
        report_mismatch("result with nothing due, status", 32'(out_status), '0);
      end else begin
        due = route_results_due.pop_front();
        if (out_status !== due.status)
          report_mismatch("status", 32'(out_status), 32'(due.status));
        if (out_sink_out !== due.sink)
          report_mismatch("sink", 32'(out_sink_out), 32'(due.sink));
        if (out_new_source !== due.new_src)
          report_mismatch("new source", out_new_source, due.new_src);
        if (out_new_destination !== due.new_dst)
          report_mismatch("new destination", out_new_destination, due.new_dst);
        if (out_header_checksum !== due.csum)
          report_mismatch("checksum", 32'(out_header_checksum), 32'(due.csum));
        if (due.status <= ST_UNSUB_DONE) status_tally[due.status]++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, route_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run_phases
    logic [31:0] offsets[PHASES];
    logic [31:0] host_a;
    logic [31:0] host_absent;
    host_a      = 32'hC0A8_0001;
    host_absent = 32'h0A00_0001;
    offsets     = '{OFFSET_RESET, 32'h0, 32'hFFFF_FFFF, $urandom(), 32'h1, 32'h8000_0000};
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = ($urandom() & 32'hFFFF_FF00) | i;
    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) sub_valid[i] = 1'b0;
    for (int i = 0; i < 7; i++) status_tally[i] = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      @(posedge clk);
      send_idle_pct <= (ph < 2) ? 13 : (ph < 4) ? 50 : 0;
      recv_idle_pct <= (ph < 2) ? 50 : (ph < 4) ? 13 : 0;
      if (ph != 0) program_offset(offsets[ph]);
      if (ph == 0) begin
        queue_item(KIND_PACKET, host_a, 32'h0A0B_0C0D, $urandom(), $urandom(), 16'h4006,
                   8'h00, MIN_HEADER_BYTES);
        queue_item(KIND_PACKET, host_a, $urandom(), $urandom(), $urandom(), 16'h4011,
                   8'h00, 16'd0);
        queue_item(KIND_SUBSCRIBE, host_a, '0, '0, '0, '0, 8'hFF, '0);
        queue_item(KIND_SUBSCRIBE, host_a, '0, '0, '0, '0, 8'h05, '0);
        queue_item(KIND_PACKET, host_a, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF, 8'hFF, MIN_HEADER_BYTES);
        queue_item(KIND_PACKET_ALT, host_a, '0, '0, '0, '0, '0, 16'hFFFF);
        queue_item(KIND_PACKET, host_a, $urandom(), $urandom(), $urandom(), 16'h4006,
                   8'h00, 16'd19);
        queue_item(KIND_UNSUBSCRIBE, host_absent, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < TABLE_ENTRIES_DEF - 1; i++)
          queue_item(KIND_SUBSCRIBE, addr_pool[i], '0, '0, '0, '0, 8'(i + 1), '0);
        queue_item(KIND_SUBSCRIBE, addr_pool[15], '0, '0, '0, '0, 8'h80, '0);
        queue_item(KIND_SUBSCRIBE, addr_pool[3], '0, '0, '0, '0, 8'h7F, '0);
        queue_item(KIND_UNSUBSCRIBE, host_a, '0, '0, '0, '0, '0, '0);
        queue_item(KIND_PACKET, host_a, $urandom(), $urandom(), $urandom(), 16'h4006,
                   8'h00, 16'd1500);
        queue_item(KIND_SUBSCRIBE, addr_pool[15], '0, '0, '0, '0, 8'h80, '0);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) items_to_send.push_back(random_item());
      if (ph == 2) begin
        while (items_accepted < 10 + ph * ITEMS_PER_PHASE) @(posedge clk);
        stall_asked <= stall_asked + 1;
      end
      while (items_to_send.size() != 0 || in_valid || route_results_due.size() != 0)
        @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items over %0d offset settings, %0d results checked, %0d mismatches",
             items_accepted, PHASES, results_checked, mismatches);
    $display({"delivered %0d, no sink %0d, too short %0d, subscribed %0d, present %0d, ",
              "table full %0d, unsubscribed %0d"},
             status_tally[ST_DELIVERED], status_tally[ST_NO_SINK],
             status_tally[ST_TOO_SHORT], status_tally[ST_SUBSCRIBED],
             status_tally[ST_PRESENT], status_tally[ST_TABLE_FULL],
             status_tally[ST_UNSUB_DONE]);
    if (mismatches == 0 && route_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
